// ===== src/integer_to_ascii_formatter_defines.svh =====
// Assertion macros used by the checker file of the integer to ASCII formatter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Implication in the same cycle, checked outside reset.
`define ITAF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Implication into the next cycle, checked outside reset.
`define ITAF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next cycle check failed");

// Check on the cycle that follows a reset cycle.
`define ITAF_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("reset check failed");

`endif

// ===== src/itaf_pkg.sv =====
// Shared types, constants and character helper for the integer to ASCII formatter.
// Used by the front, back and top level modules; depends on nothing else.
package itaf_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 4;
  localparam int unsigned DigitW = 4;
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned DigitIdxW = 4;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = 1;
  localparam int unsigned QCountW = 2;

  localparam logic [1:0] CMD_SDEC = 2'd0;
  localparam logic [1:0] CMD_UDEC = 2'd1;
  localparam logic [1:0] CMD_HEXL = 2'd2;
  localparam logic [1:0] CMD_HEXU = 2'd3;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  localparam logic [ValueW-1:0] RecipTen = 32'hcccc_cccd;
  localparam int unsigned RecipShift = 35;

  typedef struct packed {
    logic neg;
    logic hex;
    logic upper;
    logic [ValueW-1:0] mag;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [DigitW-1:0] d, input logic upper);
    logic [7:0] base;
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + {4'b0, d};
    end else begin
      base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      digit_char = base + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

// ===== src/itaf_front.sv =====
// Front end: accepts input transactions, works out sign, magnitude and radix,
// and holds the resulting jobs in a two-entry queue. Depends on itaf_pkg.
module itaf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [itaf_pkg::ValueW-1:0]  in_value,
  input  logic [1:0]                   in_cmd,
  output logic                         job_valid,
  input  logic                         job_pop,
  output itaf_pkg::job_t               job
);

  itaf_pkg::job_t                entries_r [itaf_pkg::QDepth];
  logic [itaf_pkg::QPtrW-1:0]    wr_ptr_r;
  logic [itaf_pkg::QPtrW-1:0]    rd_ptr_r;
  logic [itaf_pkg::QCountW-1:0]  count_r;
  logic [itaf_pkg::QCountW-1:0]  count_nxt;
  logic                          push;
  logic                          pop;
  itaf_pkg::job_t                new_job;

  assign in_stall  = (count_r == itaf_pkg::QCountW'(itaf_pkg::QDepth));
  assign push      = in_valid && !in_stall;
  assign job_valid = (count_r != '0);
  assign pop       = job_pop && job_valid;
  assign job       = entries_r[rd_ptr_r];

  always_comb begin
    new_job.neg   = (in_cmd == itaf_pkg::CMD_SDEC) && in_value[itaf_pkg::ValueW-1];
    new_job.hex   = (in_cmd == itaf_pkg::CMD_HEXL) || (in_cmd == itaf_pkg::CMD_HEXU);
    new_job.upper = (in_cmd == itaf_pkg::CMD_HEXU);
    new_job.mag   = new_job.neg ? ('0 - in_value) : in_value;
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= new_job;
    end
  end

endmodule

// ===== src/itaf_back.sv =====
// Back end: takes one job from the queue, extracts its digits one per cycle
// and sends the characters through the output register. Depends on itaf_pkg.
module itaf_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  output logic                         job_pop,
  input  itaf_pkg::job_t               job,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_char_code,
  output logic                         out_last,
  output logic [itaf_pkg::CountW-1:0]  out_char_count
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_SIGN  = 2'd2;
  localparam logic [1:0] ST_DIGIT = 2'd3;

  logic [1:0]                       state_r;
  logic [1:0]                       state_nxt;
  logic [itaf_pkg::ValueW-1:0]      mag_r;
  logic                             neg_r;
  logic                             hex_r;
  logic                             upper_r;
  logic [itaf_pkg::DigitIdxW-1:0]   nd_r;
  logic [itaf_pkg::DigitIdxW-1:0]   idx_r;
  logic [itaf_pkg::CountW-1:0]      total_r;
  logic [itaf_pkg::DigitW-1:0]      digits_r [itaf_pkg::MaxDigits];

  logic                             out_valid_r;
  logic [7:0]                       out_char_r;
  logic                             out_last_r;
  logic [itaf_pkg::CountW-1:0]      out_count_r;

  logic [2*itaf_pkg::ValueW-1:0]    prod;
  logic [itaf_pkg::ValueW-1:0]      quot;
  logic [itaf_pkg::DigitW-1:0]      q_times_ten;
  logic [itaf_pkg::DigitW-1:0]      digit;
  logic [itaf_pkg::ValueW-1:0]      mag_nxt;
  logic                             can_load;
  logic                             is_final;

  assign job_pop  = (state_r == ST_IDLE) && job_valid;
  assign can_load = !out_valid_r || !out_stall;
  assign is_final = (idx_r == '0);

  always_comb begin
    prod        = {{itaf_pkg::ValueW{1'b0}}, mag_r} * {{itaf_pkg::ValueW{1'b0}}, itaf_pkg::RecipTen};
    quot        = itaf_pkg::ValueW'(prod >> itaf_pkg::RecipShift);
    q_times_ten = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    if (hex_r) begin
      digit   = mag_r[itaf_pkg::DigitW-1:0];
      mag_nxt = mag_r >> itaf_pkg::DigitW;
    end else begin
      digit   = mag_r[itaf_pkg::DigitW-1:0] - q_times_ten;
      mag_nxt = quot;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (mag_nxt == '0) begin
          state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (can_load) begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (can_load && is_final) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (((state_r == ST_SIGN) || (state_r == ST_DIGIT)) && can_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          mag_r   <= job.mag;
          neg_r   <= job.neg;
          hex_r   <= job.hex;
          upper_r <= job.upper;
          nd_r    <= '0;
        end
      end
      ST_CONV: begin
        digits_r[nd_r] <= digit;
        mag_r          <= mag_nxt;
        nd_r           <= nd_r + 1'b1;
        idx_r          <= nd_r;
        total_r        <= nd_r + 4'd1 + {3'b000, neg_r};
      end
      ST_SIGN: begin
        if (can_load) begin
          out_char_r  <= itaf_pkg::CHAR_MINUS;
          out_last_r  <= 1'b0;
          out_count_r <= '0;
        end
      end
      ST_DIGIT: begin
        if (can_load) begin
          out_char_r  <= itaf_pkg::digit_char(digits_r[idx_r], upper_r);
          out_last_r  <= is_final;
          out_count_r <= is_final ? total_r : '0;
          if (!is_final) begin
            idx_r <= idx_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_char_code  = out_char_r;
  assign out_last       = out_last_r;
  assign out_char_count = out_count_r;

endmodule

// ===== src/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter.
// Instantiates itaf_front and itaf_back; depends on itaf_pkg.
//
// Usage: each input transaction carries a 32-bit value and a 2-bit format code
// (signed decimal, unsigned decimal, lowercase hex, uppercase hex). The block
// answers with one output transaction per character, most significant digit
// first, with a leading minus sign for negative signed values. The final
// character has out_last set and out_char_count holding the character total;
// on all other characters out_char_count is zero.
// A two-entry job queue sits between the front end and the digit engine, so
// up to two further values are accepted while one is being printed.
// From input acceptance to the first character, a value passes into the queue, is
// loaded into the digit engine, has its D digits extracted (D is 1 to 10 decimal,
// 1 to 8 hex) by a reciprocal multiply for decimal or by shifts for hex, and then
// reaches the output register. The digit engine takes the next value only after
// the last character of the current one has entered the output register.
// When the receiver stalls, the output register holds its character and the
// digit engine waits. Reset empties the queue and the output register.
module integer_to_ascii_formatter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [itaf_pkg::ValueW-1:0]  in_value,
  input  logic [1:0]                   in_cmd,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_char_code,
  output logic                         out_last,
  output logic [itaf_pkg::CountW-1:0]  out_char_count
);

  logic            job_valid;
  logic            job_pop;
  itaf_pkg::job_t  job;

  itaf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .in_cmd    (in_cmd),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job)
  );

  itaf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (job_valid),
    .job_pop        (job_pop),
    .job            (job),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_code  (out_char_code),
    .out_last       (out_last),
    .out_char_count (out_char_count)
  );

endmodule

// ===== src/itaf_checker.sv =====
// Port-level checker for the integer to ASCII formatter and its bind statement.
// Depends on itaf_pkg and the assertion macros in the defines header.
`include "integer_to_ascii_formatter_defines.svh"

module itaf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [7:0]                   out_char_code,
  input logic                         out_last,
  input logic [itaf_pkg::CountW-1:0]  out_char_count
);

  logic                         count_in_range;
  logic [8+itaf_pkg::CountW:0]  out_payload;

  assign count_in_range = (out_char_count != '0) && (out_char_count <= 4'd11);
  assign out_payload    = {out_char_code, out_last, out_char_count};

  `ITAF_ASSERT_RST(a_reset_clears_output, !out_valid && !in_stall)
  `ITAF_ASSERT_IMP(a_count_only_on_last, out_valid && !out_last, out_char_count == '0)
  `ITAF_ASSERT_IMP(a_last_count_range, out_valid && out_last, count_in_range)
  `ITAF_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(out_payload))

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_char_code  (out_char_code),
  .out_last       (out_last),
  .out_char_count (out_char_count)
);

// ===== test/integer_to_ascii_formatter_tb.sv =====
`timescale 1ns / 1ps
// Testbench for integer_to_ascii_formatter: drives values in all four formats and
// checks every emitted character against an internal prediction. Depends on itaf_pkg.
module integer_to_ascii_formatter_tb;

  typedef struct packed {
    logic [7:0]                  code;
    logic                        last;
    logic [itaf_pkg::CountW-1:0] count;
  } char_t;

  localparam logic [8*16-1:0] HexLower = "0123456789abcdef";
  localparam logic [8*16-1:0] HexUpper = "0123456789ABCDEF";

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [itaf_pkg::ValueW-1:0]  in_value;
  logic [1:0]                   in_cmd;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [7:0]                   out_char_code;
  logic                         out_last;
  logic [itaf_pkg::CountW-1:0]  out_char_count;

  char_t expected_chars[$];
  int    mismatch_count = 0;
  int    values_sent = 0;
  int    chars_checked = 0;
  bit    tx_idle_en = 1'b1;
  logic  rx_idle_en = 1'b1;
  logic  rx_hold = 1'b0;
  int    rx_burst = 0;

  integer_to_ascii_formatter uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_cmd         (in_cmd),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_code  (out_char_code),
    .out_last       (out_last),
    .out_char_count (out_char_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] table_char(input logic [3:0] d, input logic upper);
    logic [8*16-1:0] tbl;
    tbl = upper ? HexUpper : HexLower;
    return tbl[(15 - d) * 8 +: 8];
  endfunction

  function automatic void predict_chars(input logic [itaf_pkg::ValueW-1:0] value,
                                        input logic [1:0] cmd);
    logic [itaf_pkg::ValueW-1:0] mag;
    logic [7:0]                  text[$];
    logic [7:0]                  rev[$];
    char_t                       c;
    int                          n;
    mag = value;
    if (cmd == itaf_pkg::CMD_SDEC && value[itaf_pkg::ValueW-1]) begin
      text.push_back(itaf_pkg::CHAR_MINUS);
      mag = -value;
    end
    do begin
      if (cmd == itaf_pkg::CMD_HEXL || cmd == itaf_pkg::CMD_HEXU) begin
        rev.push_back(table_char(mag[3:0], cmd == itaf_pkg::CMD_HEXU));
        mag = mag >> 4;
      end else begin
        rev.push_back(table_char(4'(mag % 10), 1'b0));
        mag = mag / 10;
      end
    end while (mag != 0);
    while (rev.size() != 0) text.push_back(rev.pop_back());
    n = text.size();
    for (int k = 0; k < n; k++) begin
      c.code = text[k];
      c.last = (k == n - 1);
      c.count = c.last ? itaf_pkg::CountW'(n) : '0;
      expected_chars.push_back(c);
    end
  endfunction

  task automatic check_char();
    char_t want;
    if (expected_chars.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("ERROR: unexpected character code %02h last %0b count %0d",
                 out_char_code, out_last, out_char_count);
    end else begin
      want = expected_chars.pop_front();
      if (want.code !== out_char_code || want.last !== out_last ||
          want.count !== out_char_count) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: char %0d: expected %02h/%0b/%0d, got %02h/%0b/%0d",
                   chars_checked, want.code, want.last, want.count,
                   out_char_code, out_last, out_char_count);
      end
    end
    chars_checked++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_char();
    if (rx_burst > 0) begin
      rx_burst--;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      rx_burst = $urandom_range(1, 11);
    end
    out_stall <= rx_hold || (rx_burst > 0);
  end

  task automatic send_value(input logic [itaf_pkg::ValueW-1:0] value, input logic [1:0] cmd);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_cmd <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_chars(value, cmd);
    values_sent++;
  endtask

  task automatic end_stream();
    in_valid <= 1'b0;
  endtask

  task automatic wait_all_chars();
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  function automatic logic [itaf_pkg::ValueW-1:0] random_operand();
    logic [itaf_pkg::ValueW-1:0] p;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return -itaf_pkg::ValueW'($urandom_range(1, 1000));
      3: begin
        p = 1;
        if ($urandom_range(0, 1) == 0) repeat ($urandom_range(0, 9)) p = p * 10;
        else repeat ($urandom_range(0, 7)) p = p << 4;
        return p + itaf_pkg::ValueW'($urandom_range(0, 2)) - 1;
      end
      default: return 32'h8000_0000 ^ itaf_pkg::ValueW'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic test_directed();
    for (int f = 0; f < 4; f++) begin
      send_value(32'h0000_0000, 2'(f));
      send_value(32'h8000_0000, 2'(f));
      send_value(32'hFFFF_FFFF, 2'(f));
    end
    send_value(32'h7FFF_FFFF, itaf_pkg::CMD_SDEC);
    send_value(32'd1, itaf_pkg::CMD_SDEC);
    send_value(32'd9, itaf_pkg::CMD_UDEC);
    send_value(32'd10, itaf_pkg::CMD_UDEC);
    send_value(32'd1_000_000_000, itaf_pkg::CMD_SDEC);
    send_value(32'd4_000_000_000, itaf_pkg::CMD_UDEC);
    send_value(32'd15, itaf_pkg::CMD_HEXL);
    send_value(32'd16, itaf_pkg::CMD_HEXU);
    send_value(32'hDEAD_BEEF, itaf_pkg::CMD_HEXL);
    send_value(32'hABCD_EF01, itaf_pkg::CMD_HEXU);
    send_value(32'h0123_4567, itaf_pkg::CMD_HEXU);
    end_stream();
  endtask

  task automatic test_random();
    repeat (150) send_value(random_operand(), 2'($urandom_range(0, 3)));
    end_stream();
  endtask

  task automatic test_drain_pause();
    repeat (10) send_value(random_operand(), 2'($urandom_range(0, 3)));
    end_stream();
    wait_all_chars();
    repeat (10) send_value(random_operand(), 2'($urandom_range(0, 3)));
    end_stream();
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (24) send_value(-itaf_pkg::ValueW'($urandom_range(1_000_000, 2_000_000_000)),
                           itaf_pkg::CMD_SDEC);
    end_stream();
    wait_all_chars();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_back_to_back();
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    repeat (30) send_value(random_operand(), 2'($urandom_range(0, 3)));
    end_stream();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    in_cmd = itaf_pkg::CMD_SDEC;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_drain_pause();
    test_backpressure();
    test_back_to_back();
    wait_all_chars();
    repeat (30) @(posedge clk);
    $display("Sent %0d values and checked %0d characters across all four formats,",
             values_sent, chars_checked);
    $display("including zero, sign extremes, long output stalls and back-to-back traffic.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
